// File: design/rfm_pkg.sv
`timescale 1ns / 1ps

package rfm_pkg;

  localparam int unsigned CLK_HZ_W = 27;
  localparam int unsigned FREQ_W   = 27;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned STEP_W   = $clog2(FREQ_W);

  localparam logic [CLK_HZ_W-1:0] CLK_HZ_RESET = 27'd8000000;

  typedef struct packed {
    logic done;
    logic overflow;
  } meas_t;

  typedef struct packed {
    logic running;
    logic busy;
  } div_stat_t;

endpackage

// File: design/rfm_edge_counter.sv
`timescale 1ns / 1ps

module rfm_edge_counter import rfm_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  sample_i,
  output logic                  measuring_o,
  output meas_t                 meas_o,
  output logic [COUNT_BITS-1:0] count_o
);

  logic                  prev_q, prev_d;
  logic                  measuring_q, measuring_d;
  logic                  ovf_q, ovf_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  rising;
  logic                  sat;
  logic                  ovf_n;
  logic [COUNT_BITS-1:0] count_n;

  assign rising  = !prev_q && sample_i;
  assign sat     = (count_q == {COUNT_BITS{1'b1}});
  assign ovf_n   = ovf_q || sat;
  assign count_n = sat ? count_q : count_q + COUNT_BITS'(1);

  always_comb begin
    prev_d      = prev_q;
    measuring_d = measuring_q;
    ovf_d       = ovf_q;
    count_d     = count_q;
    meas_o      = '0;
    if (accept_i) begin
      prev_d = sample_i;
      if (!measuring_q) begin
        if (rising) begin
          measuring_d = 1'b1;
          ovf_d       = 1'b0;
          count_d     = '0;
        end
      end else begin
        ovf_d   = ovf_n;
        count_d = count_n;
        if (rising) begin
          measuring_d     = 1'b0;
          meas_o.done     = 1'b1;
          meas_o.overflow = ovf_n;
        end
      end
    end
  end

  assign count_o     = count_n;
  assign measuring_o = measuring_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 1'b1;
      measuring_q <= 1'b0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
    end else begin
      prev_q      <= prev_d;
      measuring_q <= measuring_d;
      ovf_q       <= ovf_d;
      count_q     <= count_d;
    end
  end

endmodule

// File: design/rfm_serial_div.sv
`timescale 1ns / 1ps

module rfm_serial_div import rfm_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  meas_t                 meas_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic [CLK_HZ_W-1:0]   clock_hz_i,
  input  logic                  out_stall_i,
  output div_stat_t             stat_o,
  output logic                  out_valid_o,
  output logic [FREQ_W-1:0]     freq_o,
  output logic [COUNT_BITS-1:0] period_o,
  output logic                  too_slow_o
);

  logic                  running_q;
  logic [STEP_W-1:0]     step_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [FREQ_W-1:0]     quo_q;
  logic [COUNT_BITS-1:0] divisor_q;
  logic                  slow_q;
  logic                  out_valid_q;
  logic [FREQ_W-1:0]     freq_q;
  logic [COUNT_BITS-1:0] period_q;
  logic                  too_slow_q;

  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;
  logic [COUNT_BITS-1:0] rem_d;
  logic [FREQ_W-1:0]     quo_d;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[FREQ_W-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign ge    = !diff[COUNT_BITS];
  assign rem_d = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  assign quo_d = {quo_q[FREQ_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (meas_i.done && !running_q && !out_valid_q) begin
        running_q <= 1'b1;
        step_q    <= STEP_W'(FREQ_W - 1);
      end else if (running_q) begin
        if (step_q == '0) begin
          running_q   <= 1'b0;
          out_valid_q <= 1'b1;
        end else begin
          step_q <= step_q - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (meas_i.done && !running_q && !out_valid_q) begin
      rem_q     <= '0;
      quo_q     <= meas_i.overflow ? '0 : clock_hz_i;
      divisor_q <= count_i;
      slow_q    <= meas_i.overflow;
    end else if (running_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (step_q == '0) begin
        freq_q     <= quo_d;
        period_q   <= divisor_q;
        too_slow_q <= slow_q;
      end
    end
  end

  assign stat_o.running = running_q;
  assign stat_o.busy    = running_q || out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign freq_o         = freq_q;
  assign period_o       = period_q;
  assign too_slow_o     = too_slow_q;

endmodule

// File: design/reciprocal_frequency_meter.sv
// Throughput: one sample per cycle while no division is pending; the divider makes one
// quotient bit per cycle, so once a start edge is taken while the divider is busy, further
// samples stall (in_stall_o) until the previous result has been taken.
// Reset (async, active low): clock_hz = 8000000, waiting for a start edge,
// previous level high, no result pending.
`timescale 1ns / 1ps

module reciprocal_frequency_meter import rfm_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CLK_HZ_W-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [FREQ_W-1:0]   frequency_hz_o,
  output logic [PERIOD_W-1:0] period_ticks_o,
  output logic                too_slow_o
);

  logic [CLK_HZ_W-1:0]   clock_hz_q;
  logic                  accept;
  logic                  measuring;
  meas_t                 meas;
  logic [COUNT_BITS-1:0] count;
  div_stat_t             div_stat;
  logic [COUNT_BITS-1:0] period;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= CLK_HZ_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      clock_hz_q <= cfg_data_i;
    end
  end

  assign in_stall_o = measuring && div_stat.busy;
  assign accept     = in_valid_i && !in_stall_o;

  rfm_edge_counter #(
    .COUNT_BITS(COUNT_BITS)
  ) u_counter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .sample_i   (sample_i),
    .measuring_o(measuring),
    .meas_o     (meas),
    .count_o    (count)
  );

  rfm_serial_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .meas_i     (meas),
    .count_i    (count),
    .clock_hz_i (clock_hz_q),
    .out_stall_i(out_stall_i),
    .stat_o     (div_stat),
    .out_valid_o(out_valid_o),
    .freq_o     (frequency_hz_o),
    .period_o   (period),
    .too_slow_o (too_slow_o)
  );

  if (COUNT_BITS >= PERIOD_W) begin : g_period_trunc
    assign period_ticks_o = period[PERIOD_W-1:0];
  end else begin : g_period_ext
    assign period_ticks_o = {{(PERIOD_W - COUNT_BITS){1'b0}}, period};
  end

  a_done_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas.done |-> !div_stat.busy)
    else $error("period closed while divider busy");

  a_done_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas.done |=> div_stat.running)
    else $error("divider did not start");

  a_result_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(div_stat.running))
    else $error("result without division");

  a_slow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && too_slow_o) |-> (frequency_hz_o == '0))
    else $error("too_slow with nonzero frequency");

endmodule
